// ===== rtl/gsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gsc_pkg;

  localparam int DEF_NUM_SLOTS = 4;
  localparam int DEF_TIME_BITS = 48;

  localparam int HOLD_W = 48;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 48'd3000000000;

  localparam int ST_WIRED         = 4;
  localparam int ST_WIRELESS      = 5;
  localparam int ST_RUMBLE_POWER  = 2;

  localparam int BTN_X     = 2;
  localparam int BTN_Y     = 3;
  localparam int BTN_START = 0;

  typedef enum logic [1:0] {
    REQ_HARD_STOP = 2'd0,
    REQ_STOP      = 2'd1,
    REQ_RUMBLE    = 2'd2,
    REQ_INVALID   = 2'd3
  } motor_req_t;

  localparam logic [1:0] MOTOR_STOP   = 2'd0;
  localparam logic [1:0] MOTOR_RUMBLE = 2'd1;
  localparam logic [1:0] MOTOR_BRAKE  = 2'd2;

  // axis order: main x, main y, sub x, sub y, left trigger, right trigger
  localparam int NUM_AXES = 6;
  typedef logic [NUM_AXES-1:0][7:0] axes_t;

  // result of the per-slot state lookup and update
  typedef struct packed {
    logic       in_range;
    logic       present;
    axes_t      origin;
    logic [1:0] motor_value;
    logic       motor_changed;
  } slot_res_t;

  function automatic logic [1:0] motor_map(input logic [1:0] req);
    logic [1:0] m;
    unique case (motor_req_t'(req))
      REQ_HARD_STOP: m = MOTOR_BRAKE;
      REQ_STOP:      m = MOTOR_STOP;
      REQ_RUMBLE:    m = MOTOR_RUMBLE;
      default:       m = MOTOR_STOP;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] sat_diff(input logic [7:0] v, input logic [7:0] o);
    logic signed [8:0] d;
    logic [7:0]        r;
    d = $signed({1'b0, v}) - $signed({1'b0, o});
    if (d < -9'sd128)      r = 8'h80;
    else if (d > 9'sd127)  r = 8'h7f;
    else                   r = d[7:0];
    return r;
  endfunction

  function automatic logic [7:0] floor_diff(input logic [7:0] v, input logic [7:0] o);
    return (v > o) ? (v - o) : 8'd0;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gsc_axis_map.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gsc_axis_map
  import gsc_pkg::*;
(
  input  wire logic        enable,
  input  wire axes_t       raw,
  input  wire axes_t       origin,
  output logic [3:0][7:0]  sticks,
  output logic [1:0][7:0]  triggers
);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sticks[i] = enable ? sat_diff(raw[i], origin[i]) : 8'd0;
    end
    for (int i = 0; i < 2; i++) begin
      triggers[i] = enable ? floor_diff(raw[4+i], origin[4+i]) : 8'd0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gsc_slot_state.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gsc_slot_state
  import gsc_pkg::*;
#(
  parameter int NUM_SLOTS = DEF_NUM_SLOTS,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic [1:0]           slot,
  input  wire logic [7:0]           status_byte,
  input  wire logic [7:0]           buttons_low,
  input  wire logic [7:0]           buttons_high,
  input  wire axes_t                raw,
  input  wire logic [TIME_BITS-1:0] time_now,
  input  wire logic [1:0]           motor_request,
  input  wire logic [HOLD_W-1:0]    hold_time,
  output slot_res_t                 res
);

  localparam int SIW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CMP_W = (TIME_BITS > HOLD_W) ? TIME_BITS : HOLD_W;

  logic                 slot_present [NUM_SLOTS];
  logic                 combo_held   [NUM_SLOTS];
  logic [TIME_BITS-1:0] combo_start  [NUM_SLOTS];
  logic [1:0]           motor_byte   [NUM_SLOTS];
  axes_t                origin_mem   [NUM_SLOTS];

  logic [SIW-1:0]       idx;
  logic                 in_range;
  logic                 pres;
  logic                 combo;
  logic [TIME_BITS-1:0] elapsed;
  logic                 expired;
  logic                 capture;
  logic                 held_next;
  logic [TIME_BITS-1:0] start_next;
  logic [1:0]           mv;
  logic                 wr;

  always_comb begin
    in_range = 32'(slot) < NUM_SLOTS;
    idx      = in_range ? SIW'(slot) : '0;
    pres     = status_byte[ST_WIRED] | status_byte[ST_WIRELESS];
    combo    = buttons_low[BTN_X] & buttons_low[BTN_Y] & buttons_high[BTN_START];
    elapsed  = time_now - combo_start[idx];
    expired  = CMP_W'(elapsed) >= CMP_W'(hold_time);
    capture  = pres & (~slot_present[idx] | (combo & combo_held[idx] & expired));

    held_next  = pres & combo;
    start_next = combo_start[idx];
    if (!pres || !combo) begin
      start_next = '0;
    end else if (!combo_held[idx] || expired) begin
      start_next = time_now;
    end

    mv = MOTOR_STOP;
    if (pres && status_byte[ST_RUMBLE_POWER] && !status_byte[ST_WIRELESS]) begin
      mv = motor_map(motor_request);
    end

    wr = en & in_range;

    res.in_range      = in_range;
    res.present       = in_range & pres;
    res.origin        = capture ? raw : origin_mem[idx];
    res.motor_value   = in_range ? mv : MOTOR_STOP;
    res.motor_changed = in_range & (motor_byte[idx] != mv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_present[i] <= 1'b0;
        combo_held[i]   <= 1'b0;
        combo_start[i]  <= '0;
        motor_byte[i]   <= MOTOR_STOP;
      end
    end else if (wr) begin
      slot_present[idx] <= pres;
      combo_held[idx]   <= held_next;
      combo_start[idx]  <= start_next;
      motor_byte[idx]   <= mv;
    end
  end

  always_ff @(posedge clk) begin
    if (wr && capture) begin
      origin_mem[idx] <= raw;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gamepad_slot_calibrator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Controller slot calibrator. Each transfer on the input channel carries one
// slot record and yields exactly one result, in order. A record is held in an
// input register, then the per-slot state lookup, origin correction and motor
// selection run combinationally into the result register, so a new record is
// taken every cycle and results leave at one per cycle while out_ready stays
// high. A slot's origin is captured on a present record after an absent one
// or after reset, and again after X, Y and Start have been held for hold_time
// time units (the user writes it through the cfg port only while idle, which
// the block does not enforce; reset value 3000000000). Slots at or above
// NUM_SLOTS return all-zero results, bar slot_echo, and leave the state alone.
module gamepad_slot_calibrator_unit
  import gsc_pkg::*;
#(
  parameter int NUM_SLOTS = DEF_NUM_SLOTS,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,

  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [HOLD_W-1:0]    cfg_data,

  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           slot,
  input  wire logic [7:0]           status_byte,
  input  wire logic [7:0]           buttons_low,
  input  wire logic [7:0]           buttons_high,
  input  wire logic [7:0]           main_x_raw,
  input  wire logic [7:0]           main_y_raw,
  input  wire logic [7:0]           sub_x_raw,
  input  wire logic [7:0]           sub_y_raw,
  input  wire logic [7:0]           left_trigger_raw,
  input  wire logic [7:0]           right_trigger_raw,
  input  wire logic [TIME_BITS-1:0] time_now,
  input  wire logic [1:0]           motor_request,

  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                slot_echo,
  output logic                      present,
  output logic                      wireless,
  output logic [11:0]               buttons,
  output logic signed [7:0]         main_x,
  output logic signed [7:0]         main_y,
  output logic signed [7:0]         sub_x,
  output logic signed [7:0]         sub_y,
  output logic [7:0]                left_trigger,
  output logic [7:0]                right_trigger,
  output logic [1:0]                motor_value,
  output logic                      motor_changed
);

  logic [HOLD_W-1:0]    hold_time;

  // input register
  logic                 in_full;
  logic [1:0]           r_slot;
  logic [7:0]           r_status;
  logic [7:0]           r_btn_lo;
  logic [7:0]           r_btn_hi;
  axes_t                r_raw;
  logic [TIME_BITS-1:0] r_time;
  logic [1:0]           r_req;

  logic                 advance;
  logic                 take;
  slot_res_t            sres;
  logic [3:0][7:0]      sticks;
  logic [1:0][7:0]      triggers;

  assign cfg_ready = 1'b1;
  assign advance   = ~out_valid | out_ready;
  assign in_ready  = ~in_full | advance;
  assign take      = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_time <= HOLD_RESET;
    end else if (cfg_valid) begin
      hold_time <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      r_slot   <= slot;
      r_status <= status_byte;
      r_btn_lo <= buttons_low;
      r_btn_hi <= buttons_high;
      r_raw    <= {right_trigger_raw, left_trigger_raw, sub_y_raw, sub_x_raw,
                   main_y_raw, main_x_raw};
      r_time   <= time_now;
      r_req    <= motor_request;
    end
  end

  gsc_slot_state #(
    .NUM_SLOTS (NUM_SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_state (
    .clk           (clk),
    .rst           (rst),
    .en            (in_full & advance),
    .slot          (r_slot),
    .status_byte   (r_status),
    .buttons_low   (r_btn_lo),
    .buttons_high  (r_btn_hi),
    .raw           (r_raw),
    .time_now      (r_time),
    .motor_request (r_req),
    .hold_time     (hold_time),
    .res           (sres)
  );

  gsc_axis_map u_axes (
    .enable   (sres.present),
    .raw      (r_raw),
    .origin   (sres.origin),
    .sticks   (sticks),
    .triggers (triggers)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_full) begin
      slot_echo     <= r_slot;
      present       <= sres.present;
      wireless      <= sres.present & r_status[ST_WIRELESS];
      buttons       <= sres.present ? {r_btn_hi[3:0], r_btn_lo} : 12'd0;
      main_x        <= sticks[0];
      main_y        <= sticks[1];
      sub_x         <= sticks[2];
      sub_y         <= sticks[3];
      left_trigger  <= triggers[0];
      right_trigger <= triggers[1];
      motor_value   <= sres.motor_value;
      motor_changed <= sres.motor_changed;
    end
  end

endmodule

`default_nettype wire
